### rtl/fsta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fsta_pkg;

    localparam logic [63:0] STEP_LEN_RESET = 64'd16666667;

    typedef enum logic [1:0] {
        FUNC_ADVANCE  = 2'd0,
        FUNC_STEP     = 2'd1,
        FUNC_SET_RATE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NEG      = 2'd1,
        STAT_ACC_OVF  = 2'd2,
        STAT_TICK_OVF = 2'd3
    } status_t;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } arith_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_Q,
        ST_MQ,
        ST_MR,
        ST_DF,
        ST_SUM1,
        ST_SUM2,
        ST_DP,
        ST_TCK,
        ST_MT,
        ST_MC,
        ST_DC,
        ST_DPX,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

### rtl/fsta_arith.sv
`timescale 1ns / 1ps
`default_nettype none
module fsta_arith import fsta_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire arith_req_t  req,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output arith_rsp_t       rsp,
    output logic [63:0]      x,
    output logic [63:0]      acc
);

    // Shared bit-serial unit: restoring divide or MSB-first multiply, 64 steps.
    // Divide: x = quotient, acc = remainder. Multiply: acc = low 64 bits, ovf on spill.
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        ovf_reg, ovf_next;
    logic [5:0]  cnt_reg, cnt_next;
    arith_op_t   op_reg, op_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] d_reg, d_next;

    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;
    logic [64:0] msum;

    assign trial = {acc_reg, x_reg[63]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = trial >= {1'b0, d_reg};
    assign msum  = {acc_reg, 1'b0} + (x_reg[63] ? {1'b0, d_reg} : 65'd0);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        x_next    = x_reg;
        acc_next  = acc_reg;
        d_next    = d_reg;
        if (req.start) begin
            busy_next = 1'b1;
            ovf_next  = 1'b0;
            cnt_next  = 6'd0;
            op_next   = req.op;
            acc_next  = 64'd0;
            if (req.op == OP_DIV) begin
                x_next = a;
                d_next = b;
            end else begin
                x_next = b;
                d_next = a;
            end
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 6'd1;
            x_next   = {x_reg[62:0], 1'b0};
            if (op_reg == OP_DIV) begin
                acc_next  = ge ? diff[63:0] : trial[63:0];
                x_next[0] = ge;
            end else begin
                acc_next = msum[63:0];
                ovf_next = ovf_reg | acc_reg[63] | msum[64];
            end
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
        op_reg  <= op_next;
        x_reg   <= x_next;
        acc_reg <= acc_next;
        d_reg   <= d_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign x        = x_reg;
    assign acc      = acc_reg;

endmodule
`default_nettype wire

### rtl/fixed_step_time_accumulator.sv
// Fixed-step time accumulator with a rational rate. Each input item produces exactly
// one result item. All multiplies and divides share one bit-serial unit; each operation
// holds the control state for its start, 64 shift steps and done pulse. Advance runs six
// operations plus four other steps, skips the last multiply when paused or on tick
// overflow and ends early on accumulator overflow; negative elapsed goes straight to the
// output; set rate runs three operations; step, a zero-denominator set rate and the
// unused code run one division (none when step overflows). One item is processed at a
// time; s_ready is high only while the block is idle, so the next item can be taken in
// the cycle after the previous result is loaded, and a finished result waits in the OUT
// state until the output register is free. The user must write step_length_ns through
// the cfg port only while idle; the block does not enforce this. Zero acts as one.
`timescale 1ns / 1ps
`default_nettype none
module fixed_step_time_accumulator import fsta_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [63:0] s_elapsed_ns,
    input  wire logic [63:0] s_tick_count,
    input  wire logic [31:0] s_new_rate_numerator,
    input  wire logic [31:0] s_new_rate_denominator,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [63:0]      m_first_tick,
    output logic [63:0]      m_ticks_run,
    output logic [63:0]      m_ticks_pending
);

    state_t      state_reg, state_next;
    logic        issued_reg, issued_next;
    logic [63:0] step_len_reg, step_len_next;
    logic [63:0] tick_reg, tick_next;
    logic [63:0] pend_reg, pend_next;
    logic [31:0] carry_reg, carry_next;
    logic [31:0] num_reg, num_next;
    logic [31:0] den_reg, den_next;

    logic [63:0] elapsed_reg, elapsed_next;
    logic [63:0] count_reg, count_next;
    logic [31:0] nnum_reg, nnum_next;
    logic [31:0] nden_reg, nden_next;
    logic [63:0] first_reg, first_next;

    logic [63:0] wq_reg, wq_next;
    logic [31:0] wr_reg, wr_next;
    logic [63:0] whole_reg, whole_next;
    logic [63:0] fp_reg, fp_next;
    logic [63:0] npend_reg, npend_next;
    logic [31:0] ncarry_reg, ncarry_next;

    status_t     o_status_reg, o_status_next;
    logic [63:0] o_run_reg, o_run_next;
    logic [63:0] o_pend_reg, o_pend_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic [63:0] m_first_reg, m_first_next;
    logic [63:0] m_run_reg, m_run_next;
    logic [63:0] m_pend_reg, m_pend_next;

    arith_req_t  u_req;
    arith_rsp_t  u_rsp;
    logic [63:0] u_a, u_b, u_x, u_acc;

    logic [63:0] step_eff;
    logic        op_state;
    logic        op_done;
    logic [64:0] sum1, sum2, tsum;
    logic [63:0] ticks;
    logic [63:0] tadd;
    logic        out_free;

    assign step_eff = (step_len_reg == 64'd0) ? 64'd1 : step_len_reg;
    assign sum1     = {1'b0, whole_reg} + {1'b0, wq_reg};
    assign sum2     = {1'b0, pend_reg} + {1'b0, whole_reg};
    assign ticks    = (wq_reg < count_reg) ? wq_reg : count_reg;
    assign tadd     = (state_reg == ST_STEP) ? count_reg : ticks;
    assign tsum     = {1'b0, tick_reg} + {1'b0, tadd};
    assign out_free = !m_valid_reg || m_ready;
    assign op_done  = issued_reg && u_rsp.done;

    always_comb begin
        op_state = 1'b1;
        u_req.op = OP_DIV;
        u_a      = pend_reg;
        u_b      = step_eff;
        case (state_reg)
            ST_Q: begin
                u_a = elapsed_reg;
                u_b = {32'd0, den_reg};
            end
            ST_MQ: begin
                u_req.op = OP_MUL;
                u_a      = wq_reg;
                u_b      = {32'd0, num_reg};
            end
            ST_MR: begin
                u_req.op = OP_MUL;
                u_a      = {32'd0, wr_reg};
                u_b      = {32'd0, num_reg};
            end
            ST_DF: begin
                u_a = fp_reg;
                u_b = {32'd0, den_reg};
            end
            ST_DP: begin
                u_a = npend_reg;
            end
            ST_MT: begin
                u_req.op = OP_MUL;
                u_a      = wq_reg;
            end
            ST_MC: begin
                u_req.op = OP_MUL;
                u_a      = {32'd0, carry_reg};
                u_b      = {32'd0, nden_reg};
            end
            ST_DC: begin
                u_a = fp_reg;
                u_b = {32'd0, den_reg};
            end
            ST_DPX: begin
            end
            default: begin
                op_state = 1'b0;
            end
        endcase
        u_req.start = op_state && !issued_reg;
    end

    fsta_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (u_req),
        .a       (u_a),
        .b       (u_b),
        .rsp     (u_rsp),
        .x       (u_x),
        .acc     (u_acc)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_func)
                        FUNC_ADVANCE:  state_next = s_elapsed_ns[63] ? ST_OUT : ST_Q;
                        FUNC_STEP:     state_next = ST_STEP;
                        FUNC_SET_RATE: state_next = (s_new_rate_denominator != 32'd0) ?
                                                    ST_MC : ST_DPX;
                        default:       state_next = ST_DPX;
                    endcase
                end
            end
            ST_STEP: state_next = tsum[64] ? ST_OUT : ST_DPX;
            ST_Q:    if (op_done) state_next = ST_MQ;
            ST_MQ:   if (op_done) state_next = u_rsp.ovf ? ST_OUT : ST_MR;
            ST_MR:   if (op_done) state_next = ST_DF;
            ST_DF:   if (op_done) state_next = ST_SUM1;
            ST_SUM1: state_next = sum1[64] ? ST_OUT : ST_SUM2;
            ST_SUM2: state_next = sum2[64] ? ST_OUT : ST_DP;
            ST_DP:   if (op_done) state_next = ST_TCK;
            ST_TCK:  state_next = (num_reg == 32'd0 || tsum[64]) ? ST_OUT : ST_MT;
            ST_MT:   if (op_done) state_next = ST_OUT;
            ST_MC:   if (op_done) state_next = ST_DC;
            ST_DC:   if (op_done) state_next = ST_DPX;
            ST_DPX:  if (op_done) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        issued_next   = issued_reg;
        step_len_next = step_len_reg;
        tick_next     = tick_reg;
        pend_next     = pend_reg;
        carry_next    = carry_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        elapsed_next  = elapsed_reg;
        count_next    = count_reg;
        nnum_next     = nnum_reg;
        nden_next     = nden_reg;
        first_next    = first_reg;
        wq_next       = wq_reg;
        wr_next       = wr_reg;
        whole_next    = whole_reg;
        fp_next       = fp_reg;
        npend_next    = npend_reg;
        ncarry_next   = ncarry_reg;
        o_status_next = o_status_reg;
        o_run_next    = o_run_reg;
        o_pend_next   = o_pend_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_first_next  = m_first_reg;
        m_run_next    = m_run_reg;
        m_pend_next   = m_pend_reg;

        if (cfg_valid) begin
            step_len_next = cfg_wdata;
        end
        if (u_req.start) begin
            issued_next = 1'b1;
        end else if (op_done) begin
            issued_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    elapsed_next  = s_elapsed_ns;
                    count_next    = s_tick_count;
                    nnum_next     = s_new_rate_numerator;
                    nden_next     = s_new_rate_denominator;
                    first_next    = tick_reg;
                    o_run_next    = 64'd0;
                    o_pend_next   = 64'd0;
                    o_status_next = (s_func == FUNC_ADVANCE && s_elapsed_ns[63]) ?
                                    STAT_NEG : STAT_OK;
                end
            end
            ST_STEP: begin
                if (tsum[64]) begin
                    o_status_next = STAT_TICK_OVF;
                end else begin
                    tick_next  = tsum[63:0];
                    o_run_next = count_reg;
                end
            end
            ST_Q: begin
                if (op_done) begin
                    wq_next = u_x;
                    wr_next = u_acc[31:0];
                end
            end
            ST_MQ: begin
                if (op_done) begin
                    if (u_rsp.ovf) begin
                        o_status_next = STAT_ACC_OVF;
                    end else begin
                        whole_next = u_acc;
                    end
                end
            end
            ST_MR: begin
                if (op_done) begin
                    fp_next = u_acc + {32'd0, carry_reg};
                end
            end
            ST_DF: begin
                if (op_done) begin
                    wq_next     = u_x;
                    ncarry_next = u_acc[31:0];
                end
            end
            ST_SUM1: begin
                if (sum1[64]) begin
                    o_status_next = STAT_ACC_OVF;
                end else begin
                    whole_next = sum1[63:0];
                end
            end
            ST_SUM2: begin
                if (sum2[64]) begin
                    o_status_next = STAT_ACC_OVF;
                end else begin
                    npend_next = sum2[63:0];
                end
            end
            ST_DP: begin
                if (op_done) begin
                    wq_next    = u_x;
                    whole_next = u_acc;
                end
            end
            ST_TCK: begin
                // wq holds whole pending ticks, whole holds the leftover ns
                carry_next = ncarry_reg;
                if (num_reg == 32'd0) begin
                    pend_next   = npend_reg;
                    o_pend_next = wq_reg;
                end else if (tsum[64]) begin
                    pend_next     = npend_reg;
                    o_status_next = STAT_TICK_OVF;
                end else begin
                    tick_next   = tsum[63:0];
                    o_run_next  = ticks;
                    o_pend_next = wq_reg - ticks;
                    wq_next     = wq_reg - ticks;
                end
            end
            ST_MT: begin
                if (op_done) begin
                    pend_next = whole_reg + u_acc;
                end
            end
            ST_MC: begin
                if (op_done) begin
                    fp_next = u_acc;
                end
            end
            ST_DC: begin
                if (op_done) begin
                    carry_next = u_x[31:0];
                    num_next   = nnum_reg;
                    den_next   = nden_reg;
                end
            end
            ST_DPX: begin
                if (op_done) begin
                    o_pend_next = u_x;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = o_status_reg;
                    m_first_next  = first_reg;
                    m_run_next    = o_run_reg;
                    m_pend_next   = o_pend_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            issued_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            step_len_reg <= STEP_LEN_RESET;
            tick_reg     <= 64'd0;
            pend_reg     <= 64'd0;
            carry_reg    <= 32'd0;
            num_reg      <= 32'd1;
            den_reg      <= 32'd1;
        end else begin
            state_reg    <= state_next;
            issued_reg   <= issued_next;
            m_valid_reg  <= m_valid_next;
            step_len_reg <= step_len_next;
            tick_reg     <= tick_next;
            pend_reg     <= pend_next;
            carry_reg    <= carry_next;
            num_reg      <= num_next;
            den_reg      <= den_next;
        end
        elapsed_reg  <= elapsed_next;
        count_reg    <= count_next;
        nnum_reg     <= nnum_next;
        nden_reg     <= nden_next;
        first_reg    <= first_next;
        wq_reg       <= wq_next;
        wr_reg       <= wr_next;
        whole_reg    <= whole_next;
        fp_reg       <= fp_next;
        npend_reg    <= npend_next;
        ncarry_reg   <= ncarry_next;
        o_status_reg <= o_status_next;
        o_run_reg    <= o_run_next;
        o_pend_reg   <= o_pend_next;
        m_status_reg <= m_status_next;
        m_first_reg  <= m_first_next;
        m_run_reg    <= m_run_next;
        m_pend_reg   <= m_pend_next;
    end

    assign cfg_ready       = 1'b1;
    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_first_tick    = m_first_reg;
    assign m_ticks_run     = m_run_reg;
    assign m_ticks_pending = m_pend_reg;

`ifndef ASSERT_OFF
    a_idle_unit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !u_rsp.busy)
        else $error("arith unit busy while idle");
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        den_reg != 32'd0)
        else $error("rate denominator is zero");
    a_carry_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        carry_reg < den_reg)
        else $error("rate carry not below denominator");
    a_err_no_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != STAT_OK |-> m_run_reg == 64'd0)
        else $error("error result reports ticks run");
`endif

endmodule
`default_nettype wire

### dv/fixed_step_time_accumulator_test.sv
`timescale 1ns / 1ps
module fixed_step_time_accumulator_test;
    import fsta_pkg::*;

    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        status_t     status;
        logic [63:0] first_tick;
        logic [63:0] ticks_run;
        logic [63:0] ticks_pending;
    } tick_report_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [63:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = '0;
    logic [63:0] s_elapsed_ns = '0;
    logic [63:0] s_tick_count = '0;
    logic [31:0] s_new_rate_numerator = '0;
    logic [31:0] s_new_rate_denominator = 32'd1;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [1:0]  m_status;
    logic [63:0] m_first_tick;
    logic [63:0] m_ticks_run;
    logic [63:0] m_ticks_pending;

    fixed_step_time_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_elapsed_ns(s_elapsed_ns), .s_tick_count(s_tick_count),
        .s_new_rate_numerator(s_new_rate_numerator),
        .s_new_rate_denominator(s_new_rate_denominator),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_first_tick(m_first_tick), .m_ticks_run(m_ticks_run),
        .m_ticks_pending(m_ticks_pending)
    );

    always #5 aclk = ~aclk;

    // timekeeping state mirrored from the block
    logic [63:0] step_len = STEP_LEN_RESET;
    logic [63:0] tick_idx = '0;
    logic [63:0] pend_ns = '0;
    logic [63:0] carry_ns = '0;
    logic [31:0] rate_num = 32'd1;
    logic [31:0] rate_den = 32'd1;

    tick_report_t reports_due[$];
    int errors = 0;
    int items_sent = 0;
    int reports_seen = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int idle_pct = 0;
    int stall_pct = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic predict_ticks(input logic [1:0] f, input logic [63:0] el, input logic [63:0] cnt,
                                 input logic [31:0] nn, input logic [31:0] nd,
                                 output tick_report_t e);
        logic [63:0] st, q, r, fp, whole, frac, ticks, ptick, num, den;
        st = (step_len == 0) ? 64'd1 : step_len;
        num = {32'd0, rate_num};
        den = {32'd0, rate_den};
        e.status = STAT_OK;
        e.first_tick = tick_idx;
        e.ticks_run = '0;
        e.ticks_pending = '0;
        if (f == FUNC_ADVANCE) begin
            if (el[63]) begin
                e.status = STAT_NEG;
            end else begin
                q = el / den;
                r = el % den;
                fp = r * num + carry_ns;
                whole = q * num;
                frac = fp / den;
                if (num != 0 && q > MAX64 / num) begin
                    e.status = STAT_ACC_OVF;
                end else if (frac > MAX64 - whole) begin
                    e.status = STAT_ACC_OVF;
                end else if (whole + frac > MAX64 - pend_ns) begin
                    e.status = STAT_ACC_OVF;
                end else begin
                    pend_ns = pend_ns + whole + frac;
                    carry_ns = fp % den;
                    ptick = pend_ns / st;
                    if (num == 0) begin
                        e.ticks_pending = ptick;
                    end else begin
                        ticks = (ptick < cnt) ? ptick : cnt;
                        if (ticks > MAX64 - tick_idx) begin
                            e.status = STAT_TICK_OVF;
                        end else begin
                            tick_idx += ticks;
                            pend_ns -= ticks * st;
                            e.ticks_run = ticks;
                            e.ticks_pending = pend_ns / st;
                        end
                    end
                end
            end
        end else if (f == FUNC_STEP) begin
            if (cnt > MAX64 - tick_idx) begin
                e.status = STAT_TICK_OVF;
            end else begin
                tick_idx += cnt;
                e.ticks_run = cnt;
                e.ticks_pending = pend_ns / st;
            end
        end else begin
            // zero denominator and the unused code only report
            if (f == FUNC_SET_RATE && nd != 0) begin
                carry_ns = carry_ns * {32'd0, nd} / den;
                rate_num = nn;
                rate_den = nd;
            end
            e.ticks_pending = pend_ns / st;
        end
    endtask

    task automatic send_item(input logic [1:0] f, input logic [63:0] el, input logic [63:0] cnt,
                             input logic [31:0] nn, input logic [31:0] nd);
        tick_report_t e;
        bit accepted;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_elapsed_ns <= el;
        s_tick_count <= cnt;
        s_new_rate_numerator <= nn;
        s_new_rate_denominator <= nd;
        accepted = 0;
        while (!accepted) begin
            @(negedge aclk);
            accepted = s_ready;
            @(posedge aclk);
        end
        predict_ticks(f, el, cnt, nn, nd, e);
        reports_due.push_back(e);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_step_len(input logic [63:0] v);
        bit accepted;
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        accepted = 0;
        while (!accepted) begin
            @(negedge aclk);
            accepted = cfg_ready;
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        step_len = v;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        tick_report_t e;
        if (aresetn && m_valid && m_ready) begin
            reports_seen++;
            status_seen[m_status]++;
            if (reports_due.size() == 0) begin
                report_mismatch("unexpected result", 64'd1, 64'd0);
            end else begin
                e = reports_due.pop_front();
                if (m_status !== e.status)
                    report_mismatch("status", {62'd0, m_status}, {62'd0, e.status});
                if (m_first_tick !== e.first_tick)
                    report_mismatch("first_tick", m_first_tick, e.first_tick);
                if (m_ticks_run !== e.ticks_run)
                    report_mismatch("ticks_run", m_ticks_run, e.ticks_run);
                if (m_ticks_pending !== e.ticks_pending)
                    report_mismatch("ticks_pending", m_ticks_pending, e.ticks_pending);
            end
        end
    end

    task automatic test_directed();
        send_item(FUNC_ADVANCE, 64'd16666667, 64'd1, '0, 32'd1);
        send_item(FUNC_ADVANCE, 64'd50000000, 64'd0, '0, 32'd1);   // cap of zero
        send_item(FUNC_ADVANCE, 64'd0, MAX64, '0, 32'd1);
        send_item(FUNC_ADVANCE, 64'h8000_0000_0000_0000, 64'd1, '0, 32'd1);
        send_item(FUNC_ADVANCE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, '0, 32'd1);
        send_item(FUNC_ADVANCE, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1, '0, 32'd1);
        send_item(FUNC_STEP, '0, 64'd5, '0, 32'd1);
        send_item(FUNC_STEP, '0, MAX64, '0, 32'd1);                 // tick overflow
        send_item(FUNC_SET_RATE, '0, '0, 32'd3, 32'd7);
        send_item(FUNC_ADVANCE, 64'd40000001, MAX64, '0, 32'd1);
        send_item(FUNC_SET_RATE, '0, '0, 32'd5, 32'd0);              // ignored
        send_item(2'd3, MAX64, MAX64, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // unused code
        send_item(FUNC_SET_RATE, '0, '0, 32'd0, 32'd1);              // paused
        send_item(FUNC_ADVANCE, 64'd99999999, MAX64, '0, 32'd1);
        send_item(FUNC_SET_RATE, '0, '0, 32'hFFFF_FFFF, 32'd1);
        send_item(FUNC_ADVANCE, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1, '0, 32'd1); // quotient overflow
        send_item(FUNC_ADVANCE, 64'h0000_0001_0000_0000, 64'd1, '0, 32'd1);
        send_item(FUNC_SET_RATE, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_item(FUNC_ADVANCE, 64'h7FFF_FFFF_FFFF_FFF0, 64'd1, '0, 32'd1); // pending overflow
        send_item(FUNC_SET_RATE, '0, '0, 32'd1, 32'd1);
        wait_drained();
        // tick overflow inside advance needs the index near the top
        write_step_len(64'd1);
        send_item(FUNC_STEP, '0, MAX64 - tick_idx - 64'd3, '0, 32'd1);
        send_item(FUNC_ADVANCE, 64'd10, MAX64, '0, 32'd1);
        send_item(FUNC_ADVANCE, 64'd2, 64'd1, '0, 32'd1);
        wait_drained();
        write_step_len(64'd0);                                        // zero acts as one
        send_item(FUNC_SET_RATE, '0, '0, 32'd1, 32'd1);
        wait_drained();
    endtask

    task automatic random_item();
        logic [1:0] f;
        logic [63:0] el, cnt;
        logic [31:0] nn, nd;
        int pick;
        pick = $urandom_range(99);
        f = (pick < 60) ? FUNC_ADVANCE : (pick < 78) ? FUNC_STEP :
            (pick < 95) ? FUNC_SET_RATE : 2'd3;
        pick = $urandom_range(9);
        if (pick < 6) el = {32'd0, $urandom} % (step_len * 64'd4 + 64'd5);
        else if (pick < 8) el = {1'b0, 31'($urandom), $urandom};
        else el = {$urandom, $urandom};
        pick = $urandom_range(9);
        if (pick < 6) cnt = {32'd0, $urandom_range(8)};
        else if (pick < 8) cnt = MAX64;
        else cnt = {$urandom, $urandom};
        if (f == FUNC_STEP && pick >= 8 && $urandom_range(3) != 0)
            cnt = {32'd0, $urandom_range(1000)};
        pick = $urandom_range(9);
        if (pick < 6) begin
            nn = $urandom_range(8);
            nd = $urandom_range(1, 8);
        end else if (pick < 9) begin
            nn = $urandom;
            nd = $urandom;
        end else begin
            nn = $urandom_range(3);
            nd = '0;
        end
        send_item(f, el, cnt, nn, nd);
    endtask

    task automatic test_random_phase(input int n, input int idle, input int stall,
                                     input logic [63:0] step);
        idle_pct = idle;
        stall_pct = stall;
        write_step_len(step);
        repeat (n) random_item();
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_phase(260, 0, 0, 64'd1000);
        test_random_phase(260, 46, 0, STEP_LEN_RESET);
        test_random_phase(260, 0, 46, 64'd1);
        test_random_phase(250, 19, 19, MAX64);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("covered %0d items over five step lengths, %0d results checked", items_sent,
                 reports_seen);
        $display("statuses ok %0d, negative %0d, acc overflow %0d, tick overflow %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0 && reports_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("timeout with %0d results outstanding", reports_due.size());
        $display("status: fail");
        $finish;
    end

endmodule

### fixed_step_time_accumulator.f
rtl/fsta_pkg.sv
rtl/fsta_arith.sv
rtl/fixed_step_time_accumulator.sv
dv/fixed_step_time_accumulator_test.sv
